### design/chrp_pkg.sv
package chrp_pkg;

  localparam int unsigned RingSlots    = 256;
  localparam int unsigned NodeSlots    = 32;
  localparam int unsigned ReplicaSteps = 5;
  localparam int unsigned OutLimit     = 5;
  localparam int unsigned KeyW         = 64;
  localparam int unsigned RingIdxW     = $clog2(RingSlots);
  localparam int unsigned RingCntW     = $clog2(RingSlots + 1);
  localparam int unsigned NodeIdxW     = $clog2(NodeSlots);
  localparam int unsigned StepW        = $clog2(ReplicaSteps + 1);
  localparam int unsigned OutCntW      = $clog2(OutLimit + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CAP    = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_PLACED = 2'd0,
    ST_NONE   = 2'd1,
    ST_DONE   = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Command broadcast to every ring cell.
  typedef enum logic [2:0] {
    RC_IDLE,
    RC_INSERT,
    RC_REMAP,
    RC_COMPACT,
    RC_ROTATE
  } ring_cmd_e;

  typedef struct packed {
    ring_cmd_e          cmd;
    logic [KeyW-1:0]    key;
    logic [KeyW-1:0]    owner;
  } ring_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_CHK,
    S_REMOVE,
    S_LOOKUP,
    S_WALK,
    S_RESTORE,
    S_NONE
  } state_e;

endpackage

### design/chrp_cell.sv
// One ring slot. Cells form a chain: slot i takes data from slot i-1 (insert shift)
// or slot i+1 (compaction / rotate).
module chrp_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  chrp_pkg::ring_ctl_t           ctl_i,
  input  logic                          occ_i,
  input  logic                          prev_ge_i,
  input  logic [chrp_pkg::KeyW-1:0]     prev_pos_i,
  input  logic [chrp_pkg::KeyW-1:0]     prev_own_i,
  input  logic [chrp_pkg::KeyW-1:0]     next_pos_i,
  input  logic [chrp_pkg::KeyW-1:0]     next_own_i,
  input  logic                          shift_i,
  output logic                          ge_o,
  output logic                          eq_o,
  output logic                          match_own_o,
  output logic [chrp_pkg::KeyW-1:0]     pos_o,
  output logic [chrp_pkg::KeyW-1:0]     own_o
);

  logic [chrp_pkg::KeyW-1:0] pos_q, pos_d, own_q, own_d;
  logic                      ge;

  // Compare against the broadcast key
  assign ge          = occ_i && (pos_q >= ctl_i.key);
  assign ge_o        = ge;
  assign eq_o        = occ_i && (pos_q == ctl_i.key);
  assign match_own_o = occ_i && (own_q == ctl_i.owner);
  assign pos_o       = pos_q;
  assign own_o       = own_q;

  always_comb begin
    pos_d = pos_q;
    own_d = own_q;
    case (ctl_i.cmd)
      chrp_pkg::RC_INSERT: begin
        // first cell at or above key (else the first free cell) takes the new entry, later ones shift up
        if ((ge && !prev_ge_i) || (!occ_i && !prev_ge_i && shift_i)) begin
          pos_d = ctl_i.key;
          own_d = ctl_i.owner;
        end else if (prev_ge_i) begin
          pos_d = prev_pos_i;
          own_d = prev_own_i;
        end
      end
      chrp_pkg::RC_REMAP: begin
        if (eq_o) own_d = ctl_i.owner;
      end
      chrp_pkg::RC_COMPACT, chrp_pkg::RC_ROTATE: begin
        if (shift_i) begin
          pos_d = next_pos_i;
          own_d = next_own_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      own_q <= '0;
    end else begin
      pos_q <= pos_d;
      own_q <= own_d;
    end
  end

endmodule

### design/chrp_ring.sv
// Chain of ring cells plus occupancy count.
module chrp_ring (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  chrp_pkg::ring_ctl_t             ctl_i,
  input  logic [chrp_pkg::RingIdxW-1:0]   sel_i,
  output logic [chrp_pkg::RingCntW-1:0]   count_o,
  output logic                            any_ge_o,
  output logic                            any_eq_o,
  output logic [chrp_pkg::RingIdxW-1:0]   first_ge_o,
  output logic                            any_own_o,
  output logic [chrp_pkg::RingIdxW-1:0]   first_own_o,
  output logic [chrp_pkg::KeyW-1:0]       head_pos_o,
  output logic [chrp_pkg::KeyW-1:0]       head_own_o
);

  localparam int unsigned N = chrp_pkg::RingSlots;
  logic [chrp_pkg::RingCntW-1:0] cnt_q, cnt_d;
  logic [N-1:0] occ, ge, eq, mo, shift;
  logic [chrp_pkg::KeyW-1:0] pos [N];
  logic [chrp_pkg::KeyW-1:0] own [N];

  for (genvar i = 0; i < N; i++) begin : g_occ
    assign occ[i] = (chrp_pkg::RingCntW'(i) < cnt_q);
  end

  // Per-cell shift enable
  always_comb begin
    for (int i = 0; i < N; i++) begin
      case (ctl_i.cmd)
        chrp_pkg::RC_INSERT:  shift[i] = (chrp_pkg::RingCntW'(i) == cnt_q);
        chrp_pkg::RC_COMPACT: shift[i] = (chrp_pkg::RingIdxW'(i) >= sel_i);
        chrp_pkg::RC_ROTATE:  shift[i] = 1'b1;
        default:              shift[i] = 1'b0;
      endcase
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int P = (i == 0) ? 0 : i - 1;
    localparam int X = (i == N - 1) ? 0 : i + 1;
    logic nxt_occ;
    logic [chrp_pkg::KeyW-1:0] np, no;
    // rotate wraps last live entry back from the head
    assign nxt_occ = (chrp_pkg::RingCntW'(i + 1) < cnt_q);
    assign np = (ctl_i.cmd == chrp_pkg::RC_ROTATE && !nxt_occ) ? pos[0] : pos[X];
    assign no = (ctl_i.cmd == chrp_pkg::RC_ROTATE && !nxt_occ) ? own[0] : own[X];
    chrp_cell u_cell (
      .clk_i, .rst_ni, .ctl_i,
      .occ_i      (occ[i]),
      .prev_ge_i  ((i == 0) ? 1'b0 : ge[P]),
      .prev_pos_i (pos[P]),
      .prev_own_i (own[P]),
      .next_pos_i (np),
      .next_own_i (no),
      .shift_i    (shift[i]),
      .ge_o       (ge[i]),
      .eq_o       (eq[i]),
      .match_own_o(mo[i]),
      .pos_o      (pos[i]),
      .own_o      (own[i])
    );
  end

  // Priority encode first hits
  always_comb begin
    first_ge_o  = '0;
    first_own_o = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (ge[i]) first_ge_o  = chrp_pkg::RingIdxW'(i);
      if (mo[i]) first_own_o = chrp_pkg::RingIdxW'(i);
    end
  end
  assign any_ge_o  = |ge;
  assign any_eq_o  = |eq;
  assign any_own_o = |mo;
  assign count_o   = cnt_q;
  assign head_pos_o = pos[0];
  assign head_own_o = own[0];

  always_comb begin
    cnt_d = cnt_q;
    case (ctl_i.cmd)
      chrp_pkg::RC_INSERT:  cnt_d = cnt_q + 1'b1;
      chrp_pkg::RC_COMPACT: cnt_d = cnt_q - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

endmodule

### design/chrp_members.sv
// Node capacity table: 32 entries, parallel key match.
module chrp_members (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [chrp_pkg::KeyW-1:0]   key_i,
  input  logic                        wr_i,
  input  logic                        clr_i,
  input  logic [chrp_pkg::KeyW-1:0]   cap_i,
  output logic                        hit_o,
  output logic                        zero_cap_o,
  output logic                        free_o
);

  localparam int unsigned N = chrp_pkg::NodeSlots;
  logic [chrp_pkg::KeyW-1:0] key_q [N];
  logic [chrp_pkg::KeyW-1:0] cap_q [N];
  logic [N-1:0] vld_q, hit;
  logic [chrp_pkg::NodeIdxW-1:0] hidx, fidx;

  always_comb begin
    hidx = '0;
    fidx = '0;
    for (int i = 0; i < N; i++) hit[i] = vld_q[i] && key_q[i] == key_i;
    for (int i = N - 1; i >= 0; i--) begin
      if (hit[i])    hidx = chrp_pkg::NodeIdxW'(i);
      if (!vld_q[i]) fidx = chrp_pkg::NodeIdxW'(i);
    end
  end
  assign hit_o      = |hit;
  assign free_o     = ~&vld_q;
  assign zero_cap_o = hit_o && cap_q[hidx] == '0;

  // Write to the matching entry, else the first free one
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      key_q[hit_o ? hidx : fidx] <= key_i;
      cap_q[hit_o ? hidx : fidx] <= cap_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (wr_i) vld_q[hit_o ? hidx : fidx] <= 1'b1;
    else if (clr_i && hit_o) vld_q[hidx] <= 1'b0;
  end

endmodule

### design/consistent_hash_ring_placer_top.sv
// Add and set capacity: one check state loads the result beat once the output slot is free.
// Remove: one compaction per dropped ring entry, then the done beat. Empty-ring lookup: a no-placement beat.
// Lookup: the ring turns one cell a cycle (a walk step waits while a held placement cannot
// be pushed out): start-index turns, five walk steps, then on to a whole number of turns.
// One item at a time; the final beat waits in the output register while the next item starts.
// Reset clears ring count, member valid bits, beat.
module consistent_hash_ring_placer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      op_i,
  input  logic [chrp_pkg::KeyW-1:0]       node_key_i,
  input  logic [chrp_pkg::KeyW-1:0]       virtual_key_i,
  input  logic [chrp_pkg::KeyW-1:0]       capacity_value_i,
  input  logic [chrp_pkg::KeyW-1:0]       block_key_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic [chrp_pkg::KeyW-1:0]       placed_virtual_o,
  output logic                            last_o
);

  chrp_pkg::state_e state_q, state_d;
  chrp_pkg::ring_ctl_t ctl;
  logic [1:0] op_q;
  logic [chrp_pkg::KeyW-1:0] node_q, vid_q, cap_q, blk_q;
  logic [chrp_pkg::RingIdxW-1:0] sel;
  logic [chrp_pkg::RingCntW-1:0] cnt, rot_q, rot_d, off_q, off_d, off_inc;
  logic any_ge, any_eq, any_own;
  logic [chrp_pkg::RingIdxW-1:0] first_ge, first_own;
  logic [chrp_pkg::KeyW-1:0] head_pos, head_own, mkey;
  logic [chrp_pkg::StepW-1:0] step_q, step_d;
  logic [chrp_pkg::OutCntW-1:0] nout_q, nout_d;
  logic hit, zcap, free, mwr, mclr;
  logic [1:0] st_q, st_d;
  logic [chrp_pkg::KeyW-1:0] pv_q, pv_d;
  logic lst_q, lst_d;
  logic pend_q, pend_d;
  logic [chrp_pkg::KeyW-1:0] ppv_q, ppv_d;
  logic ovld_q, ovld_d, oload, ofree;
  logic walk_end;
  logic acc;

  assign acc = in_valid_i && in_ready_o;

  chrp_ring u_ring (
    .clk_i, .rst_ni, .ctl_i(ctl), .sel_i(sel), .count_o(cnt),
    .any_ge_o(any_ge), .any_eq_o(any_eq), .first_ge_o(first_ge),
    .any_own_o(any_own), .first_own_o(first_own),
    .head_pos_o(head_pos), .head_own_o(head_own)
  );

  chrp_members u_mem (
    .clk_i, .rst_ni, .key_i(mkey), .wr_i(mwr), .clr_i(mclr), .cap_i(cap_q),
    .hit_o(hit), .zero_cap_o(zcap), .free_o(free)
  );

  // Member lookup key: node for control ops, head owner during walk
  assign mkey = (state_q == chrp_pkg::S_WALK) ? head_own : node_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q   <= op_i;
      node_q <= node_key_i;
      vid_q  <= virtual_key_i;
      cap_q  <= capacity_value_i;
      blk_q  <= block_key_i;
    end
  end

  // Output slot can take a new beat; rotation offset advances modulo the ring count
  assign ofree    = !ovld_q || out_ready_i;
  assign off_inc  = (off_q + 1'b1 == cnt) ? '0 : off_q + 1'b1;
  assign walk_end = (step_q == chrp_pkg::StepW'(chrp_pkg::ReplicaSteps)) ||
                    (nout_q == chrp_pkg::OutCntW'(chrp_pkg::OutLimit));

  // Sequencer
  always_comb begin
    state_d = state_q;
    ctl.cmd = chrp_pkg::RC_IDLE;
    ctl.key = vid_q;
    ctl.owner = node_q;
    sel = first_own;
    rot_d = rot_q; off_d = off_q; step_d = step_q; nout_d = nout_q;
    pend_d = pend_q; ppv_d = ppv_q;
    oload = 1'b0;
    st_d = st_q; pv_d = pv_q; lst_d = lst_q;
    mwr = 1'b0; mclr = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      chrp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (chrp_pkg::op_e'(op_i))
            chrp_pkg::OP_ADD:    state_d = chrp_pkg::S_ADD_CHK;
            chrp_pkg::OP_REMOVE: state_d = chrp_pkg::S_REMOVE;
            chrp_pkg::OP_CAP:    state_d = chrp_pkg::S_ADD_CHK;
            chrp_pkg::OP_LOOKUP: state_d = chrp_pkg::S_LOOKUP;
            default:             state_d = chrp_pkg::S_IDLE;
          endcase
        end
      end
      chrp_pkg::S_ADD_CHK: begin
        // act only when the result beat can be loaded
        if (ofree) begin
          oload = 1'b1;
          st_d = chrp_pkg::ST_DONE; pv_d = '0; lst_d = 1'b1;
          state_d = chrp_pkg::S_IDLE;
          if (op_q == chrp_pkg::OP_CAP) begin
            mwr = hit;
          end else if ((!any_eq && cnt >= chrp_pkg::RingCntW'(chrp_pkg::RingSlots))
                       || (!hit && !free)) begin
            st_d = chrp_pkg::ST_FULL;
          end else begin
            mwr = 1'b1;
            ctl.cmd = any_eq ? chrp_pkg::RC_REMAP : chrp_pkg::RC_INSERT;
          end
        end
      end
      chrp_pkg::S_REMOVE: begin
        // drop one owned entry a cycle
        if (any_own) ctl.cmd = chrp_pkg::RC_COMPACT;
        else if (ofree) begin
          mclr = 1'b1;
          oload = 1'b1;
          st_d = chrp_pkg::ST_DONE; pv_d = '0; lst_d = 1'b1;
          state_d = chrp_pkg::S_IDLE;
        end
      end
      chrp_pkg::S_LOOKUP: begin
        ctl.key = blk_q;
        step_d = '0; nout_d = '0; off_d = '0; pend_d = 1'b0;
        rot_d = any_ge ? chrp_pkg::RingCntW'(first_ge) : '0;
        state_d = (cnt == '0) ? chrp_pkg::S_NONE : chrp_pkg::S_WALK;
      end
      chrp_pkg::S_WALK: begin
        if (rot_q != '0) begin
          // turn the start entry to the head
          ctl.cmd = chrp_pkg::RC_ROTATE;
          rot_d = rot_q - 1'b1;
          off_d = off_inc;
        end else if (walk_end) begin
          // send the held placement as last, or no placement
          if (ofree) begin
            oload = 1'b1;
            lst_d = 1'b1;
            st_d = pend_q ? chrp_pkg::ST_PLACED : chrp_pkg::ST_NONE;
            pv_d = pend_q ? ppv_q : '0;
            pend_d = 1'b0;
            state_d = chrp_pkg::S_RESTORE;
          end
        end else if (zcap || !pend_q || ofree) begin
          // one step; a new placement pushes the held one out as not last
          ctl.cmd = chrp_pkg::RC_ROTATE;
          off_d = off_inc;
          step_d = step_q + 1'b1;
          if (!zcap) begin
            nout_d = nout_q + 1'b1;
            ppv_d = head_pos;
            pend_d = 1'b1;
            if (pend_q) begin
              oload = 1'b1;
              st_d = chrp_pkg::ST_PLACED; pv_d = ppv_q; lst_d = 1'b0;
            end
          end
        end
      end
      chrp_pkg::S_RESTORE: begin
        // turn on until the ring is back in sorted order
        if (off_q != '0) begin
          ctl.cmd = chrp_pkg::RC_ROTATE;
          off_d = off_inc;
        end else begin
          state_d = chrp_pkg::S_IDLE;
        end
      end
      chrp_pkg::S_NONE: begin
        if (ofree) begin
          oload = 1'b1;
          st_d = chrp_pkg::ST_NONE; pv_d = '0; lst_d = 1'b1;
          state_d = chrp_pkg::S_IDLE;
        end
      end
      default: state_d = chrp_pkg::S_IDLE;
    endcase
  end

  // Hold a beat until taken
  assign ovld_d = oload || (ovld_q && !out_ready_i);
  assign out_valid_o = ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chrp_pkg::S_IDLE;
      ovld_q  <= 1'b0;
      pend_q  <= 1'b0;
      ppv_q   <= '0;
      rot_q   <= '0;
      off_q   <= '0;
      step_q  <= '0;
      nout_q  <= '0;
      st_q    <= '0;
      pv_q    <= '0;
      lst_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      pend_q  <= pend_d;
      ppv_q   <= ppv_d;
      rot_q   <= rot_d;
      off_q   <= off_d;
      step_q  <= step_d;
      nout_q  <= nout_d;
      st_q    <= st_d;
      pv_q    <= pv_d;
      lst_q   <= lst_d;
    end
  end

  assign status_o = st_q;
  assign placed_virtual_o = pv_q;
  assign last_o = lst_q;

  // Ring never exceeds its capacity
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= chrp_pkg::RingCntW'(chrp_pkg::RingSlots)) else $error("ring overflow");
  // No input while busy
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == chrp_pkg::S_IDLE) else $error("ready while busy");
  // A result beat holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("beat dropped");
  // A waiting beat keeps its payload
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(placed_virtual_o) && $stable(status_o)
    && $stable(last_o)) else $error("beat changed while waiting");

endmodule

### tb/tb_consistent_hash_ring_placer_top.sv
module tb_consistent_hash_ring_placer_top;

  typedef struct packed {
    logic [1:0]                status;
    logic [chrp_pkg::KeyW-1:0] placed;
    logic                      last;
  } place_beat_t;

  // Scoreboard: shadow ring and member table, queue of pending placement beats
  class placement_board;
    logic [chrp_pkg::KeyW-1:0] ring_pos[chrp_pkg::RingSlots];
    logic [chrp_pkg::KeyW-1:0] ring_own[chrp_pkg::RingSlots];
    int unsigned               ring_len;
    logic [chrp_pkg::KeyW-1:0] mem_key[chrp_pkg::NodeSlots];
    logic [chrp_pkg::KeyW-1:0] mem_cap[chrp_pkg::NodeSlots];
    bit                        mem_ok[chrp_pkg::NodeSlots];
    place_beat_t               pending_q[$];
    int                        errors;

    function new();
      ring_len = 0;
      errors = 0;
      foreach (mem_ok[i]) mem_ok[i] = 0;
    endfunction

    function int find_node(logic [chrp_pkg::KeyW-1:0] key);
      for (int i = 0; i < chrp_pkg::NodeSlots; i++)
        if (mem_ok[i] && mem_key[i] == key) return i;
      return -1;
    endfunction

    function int free_node();
      for (int i = 0; i < chrp_pkg::NodeSlots; i++)
        if (!mem_ok[i]) return i;
      return -1;
    endfunction

    function int unsigned first_at_or_above(logic [chrp_pkg::KeyW-1:0] key);
      for (int unsigned i = 0; i < ring_len; i++)
        if (ring_pos[i] >= key) return i;
      return ring_len;
    endfunction

    function void push(logic [1:0] st, logic [chrp_pkg::KeyW-1:0] v, logic lst);
      place_beat_t b;
      b.status = st;
      b.placed = v;
      b.last = lst;
      pending_q = {pending_q, b};
    endfunction

    function logic [1:0] add_entry(logic [chrp_pkg::KeyW-1:0] node,
                                   logic [chrp_pkg::KeyW-1:0] vid,
                                   logic [chrp_pkg::KeyW-1:0] cap);
      int unsigned pos;
      bit dup;
      int m;
      pos = first_at_or_above(vid);
      dup = pos < ring_len && ring_pos[pos] == vid;
      m = find_node(node);
      if (!dup && ring_len >= chrp_pkg::RingSlots) return chrp_pkg::ST_FULL;
      if (m < 0) begin
        m = free_node();
        if (m < 0) return chrp_pkg::ST_FULL;
      end
      if (dup) begin
        ring_own[pos] = node;
      end else begin
        for (int unsigned i = ring_len; i > pos; i--) begin
          ring_pos[i] = ring_pos[i-1];
          ring_own[i] = ring_own[i-1];
        end
        ring_pos[pos] = vid;
        ring_own[pos] = node;
        ring_len++;
      end
      mem_key[m] = node;
      mem_cap[m] = cap;
      mem_ok[m] = 1;
      return chrp_pkg::ST_DONE;
    endfunction

    // Note one accepted input beat and queue the beats it causes
    function void note_input(logic [1:0] op, logic [chrp_pkg::KeyW-1:0] node,
                             logic [chrp_pkg::KeyW-1:0] vid,
                             logic [chrp_pkg::KeyW-1:0] cap,
                             logic [chrp_pkg::KeyW-1:0] blk);
      int unsigned w, idx;
      int m, n;
      logic [chrp_pkg::KeyW-1:0] hits[$];
      case (op)
        chrp_pkg::OP_ADD: begin
          push(add_entry(node, vid, cap), '0, 1'b1);
        end
        chrp_pkg::OP_REMOVE: begin
          w = 0;
          for (int unsigned r = 0; r < ring_len; r++) begin
            if (ring_own[r] != node) begin
              ring_pos[w] = ring_pos[r];
              ring_own[w] = ring_own[r];
              w++;
            end
          end
          ring_len = w;
          m = find_node(node);
          if (m >= 0) mem_ok[m] = 0;
          push(chrp_pkg::ST_DONE, '0, 1'b1);
        end
        chrp_pkg::OP_CAP: begin
          m = find_node(node);
          if (m >= 0) mem_cap[m] = cap;
          push(chrp_pkg::ST_DONE, '0, 1'b1);
        end
        default: begin
          if (ring_len > 0) begin
            idx = first_at_or_above(blk);
            if (idx >= ring_len) idx = 0;
            for (int s = 0; s < chrp_pkg::ReplicaSteps && hits.size() < chrp_pkg::OutLimit;
                 s++) begin
              m = find_node(ring_own[idx]);
              if (!(m >= 0 && mem_cap[m] == 0)) hits = {hits, ring_pos[idx]};
              idx++;
              if (idx >= ring_len) idx = 0;
            end
          end
          n = hits.size();
          if (n == 0) push(chrp_pkg::ST_NONE, '0, 1'b1);
          for (int i = 0; i < n; i++) push(chrp_pkg::ST_PLACED, hits[i], i == n - 1);
        end
      endcase
    endfunction

    task report(string what, logic [chrp_pkg::KeyW-1:0] got,
                logic [chrp_pkg::KeyW-1:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
    endtask

    // Compare one output beat with the oldest pending beat
    task check_result(logic [1:0] st, logic [chrp_pkg::KeyW-1:0] v, logic lst);
      place_beat_t e;
      if (pending_q.size() == 0) begin
        report("unexpected beat", {62'd0, st}, '0);
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status) report("status", {62'd0, st}, {62'd0, e.status});
      if (v !== e.placed) report("placed_virtual", v, e.placed);
      if (lst !== e.last) report("last", {63'd0, lst}, {63'd0, e.last});
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [1:0] op_i = '0;
  logic [chrp_pkg::KeyW-1:0] node_key_i = '0;
  logic [chrp_pkg::KeyW-1:0] virtual_key_i = '0;
  logic [chrp_pkg::KeyW-1:0] capacity_value_i = '0;
  logic [chrp_pkg::KeyW-1:0] block_key_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [1:0] status_o;
  logic [chrp_pkg::KeyW-1:0] placed_virtual_o;
  logic last_o;

  placement_board board = new();
  int idle_cycles = 0;
  bit sink_stalls = 1;
  logic [chrp_pkg::KeyW-1:0] node_pool[8];
  logic [chrp_pkg::KeyW-1:0] vid_pool[24];

  consistent_hash_ring_placer_top dut (.*);

  always #10 clk_i = ~clk_i;

  // Count cycles without any beat; abort on a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("FAIL consistent_hash_ring_placer_top");
      $finish;
    end
  end

  // Sink: check beats, stall ready at random
  int sink_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_result(status_o, placed_virtual_o, last_o);
        sink_gap = sink_stalls ? $urandom_range(0, 11) : 0;
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [chrp_pkg::KeyW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Hold valid across back-to-back beats; drop it only for a gap
  task automatic send_beat(logic [1:0] op, logic [chrp_pkg::KeyW-1:0] node,
                           logic [chrp_pkg::KeyW-1:0] vid,
                           logic [chrp_pkg::KeyW-1:0] cap,
                           logic [chrp_pkg::KeyW-1:0] blk, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    node_key_i <= node;
    virtual_key_i <= vid;
    capacity_value_i <= cap;
    block_key_i <= blk;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(op, node, vid, cap, blk);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [chrp_pkg::KeyW-1:0] ones;
    int pick;
    ones = '1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty ring, extremes, duplicates, zero capacity, unknown nodes
    send_beat(chrp_pkg::OP_LOOKUP, 0, 0, 0, 0, 0);
    send_beat(chrp_pkg::OP_REMOVE, 5, 0, 0, 0, 0);
    send_beat(chrp_pkg::OP_CAP, 5, 0, 7, 0, 0);
    send_beat(chrp_pkg::OP_ADD, 0, 0, 0, 0, 0);
    send_beat(chrp_pkg::OP_LOOKUP, 0, 0, 0, ones, 0);
    send_beat(chrp_pkg::OP_ADD, ones, ones, ones, 0, 1);
    send_beat(chrp_pkg::OP_LOOKUP, 0, 0, 0, 1, 1);
    send_beat(chrp_pkg::OP_ADD, 1, 100, 3, 0, 1);
    send_beat(chrp_pkg::OP_ADD, 2, 100, 4, 0, 1);
    send_beat(chrp_pkg::OP_LOOKUP, 0, 0, 0, 50, 1);
    send_beat(chrp_pkg::OP_CAP, 2, 0, 0, 0, 1);
    send_beat(chrp_pkg::OP_LOOKUP, 0, 0, 0, 50, 1);
    send_beat(chrp_pkg::OP_CAP, ones, 0, 0, 0, 1);
    send_beat(chrp_pkg::OP_LOOKUP, 0, 0, 0, ones, 1);
    send_beat(chrp_pkg::OP_REMOVE, 0, 0, 0, 0, 1);
    send_beat(chrp_pkg::OP_LOOKUP, 0, 0, 0, 0, 1);
    send_beat(chrp_pkg::OP_REMOVE, 2, 0, 0, 0, 1);
    send_beat(chrp_pkg::OP_REMOVE, ones, 0, 0, 0, 1);
    send_beat(chrp_pkg::OP_LOOKUP, 0, 0, 0, 7, 1);
    // Fill the member table to force a table-full status
    for (int i = 0; i < chrp_pkg::NodeSlots + 1; i++)
      send_beat(chrp_pkg::OP_ADD, 64'h1000 + i, 64'h5000 + i, 1, 0, i > 20);
    drain();
    for (int i = 0; i < chrp_pkg::NodeSlots; i++)
      send_beat(chrp_pkg::OP_REMOVE, 64'h1000 + i, 0, 0, 0, 0);

    // Hold off until every pending beat has come
    drain();

    foreach (node_pool[i]) node_pool[i] = (i == 0) ? ones : rand64();
    foreach (vid_pool[i]) vid_pool[i] = rand64();
    for (int n = 0; n < 186; n++) begin
      if (n == 60) drain();
      sink_stalls = !(n >= 100 && n < 130);
      pick = $urandom_range(0, 9);
      if (pick < 3)
        send_beat(chrp_pkg::OP_ADD, node_pool[$urandom_range(0, 7)],
                  vid_pool[$urandom_range(0, 23)],
                  ($urandom_range(0, 3) == 0) ? '0 : rand64(), rand64(), n < 80);
      else if (pick == 3)
        send_beat(chrp_pkg::OP_REMOVE, ($urandom_range(0, 4) == 0) ? rand64() :
                  node_pool[$urandom_range(0, 7)], rand64(), rand64(), rand64(), 1);
      else if (pick == 4)
        send_beat(chrp_pkg::OP_CAP, node_pool[$urandom_range(0, 7)], rand64(),
                  ($urandom_range(0, 1) == 0) ? '0 : rand64(), rand64(), 1);
      else
        send_beat(chrp_pkg::OP_LOOKUP, rand64(), rand64(), rand64(),
                  ($urandom_range(0, 2) == 0) ? vid_pool[$urandom_range(0, 23)] : rand64(),
                  n > 30);
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("PASS consistent_hash_ring_placer_top");
    end else begin
      $display("FAIL consistent_hash_ring_placer_top");
    end
    $finish;
  end

endmodule
